// ===== src/sfts_pkg.sv =====
// sfts_pkg: shared types and constants for the sensor frame timestamp syncer.
// No dependencies.
package sfts_pkg;

    localparam int unsigned HistoryDepthDefault = 128;
    localparam logic [63:0] ThresholdReset     = 64'd20000000;

    // sample kinds
    typedef enum logic [2:0] {
        FUNC_POSE  = 3'd0,
        FUNC_GYRO  = 3'd1,
        FUNC_ACCEL = 3'd2,
        FUNC_CAM0  = 3'd3,
        FUNC_CAM1  = 3'd4
    } t_func;

    // status codes
    localparam logic [1:0] STAT_NONE   = 2'd0;
    localparam logic [1:0] STAT_WITHIN = 2'd1;
    localparam logic [1:0] STAT_OUT    = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic push;       // write motion sample into its ring
        logic cam0;       // latch camera0 info
        logic cam1;       // latch camera1 info, clear marks on match
        logic scan_start; // clear best trackers, begin scan
        logic scan_step;  // compare one slot in all three rings
        logic finish;     // compute result fields into output register
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic match;     // camera1 beat completes a pair
        logic scan_last; // current scan index is the last one
    } t_stat;

endpackage

// ===== src/sfts_datapath.sv =====
// sfts_datapath: ring histories, camera registers, nearest-slot scan unit.
// Depends on sfts_pkg.
module sfts_datapath
    import sfts_pkg::*;
#(
    parameter int unsigned HISTORY_DEPTH = HistoryDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic [2:0]  i_func,
    input  logic [63:0] i_sample_time,
    input  logic [31:0] i_frame_number,
    input  logic        i_frame_present,
    input  logic        i_cfg_we,
    input  logic [63:0] i_cfg_data,
    output logic [31:0] o_set_frame_number,
    output logic [63:0] o_set_time,
    output logic [1:0]  o_pose_status,
    output logic [6:0]  o_pose_slot,
    output logic [63:0] o_pose_gap,
    output logic [1:0]  o_gyro_status,
    output logic [6:0]  o_gyro_slot,
    output logic [63:0] o_gyro_gap,
    output logic [1:0]  o_accel_status,
    output logic [6:0]  o_accel_slot,
    output logic [63:0] o_accel_gap
);
    localparam int unsigned AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int unsigned FW = $clog2(HISTORY_DEPTH + 1);
    localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;

    logic [63:0] r_mem [3][HISTORY_DEPTH];
    logic [FW-1:0] r_fill [3];
    logic [AW-1:0] r_wr   [3];
    logic [63:0] r_thresh;
    logic [31:0] r_left_num, r_right_num;
    logic [63:0] r_left_time;
    logic        r_left_held, r_right_held;

    // scan state
    logic [AW-1:0] r_idx;       // address presented to memories
    logic [AW-1:0] r_cmp_idx;   // slot of registered read data
    logic          r_cmp_vld;
    logic [63:0]   r_rd [3];
    logic          r_found [3];
    logic [63:0]   r_best_d [3];
    logic [63:0]   r_best_t [3];
    logic [AW-1:0] r_best_s [3];

    logic [1:0] w_sel;
    assign w_sel = i_func[1:0];

    // match check uses the incoming camera1 beat
    assign o_stat.match = r_left_held && i_frame_present && (r_left_num == i_frame_number);
    assign o_stat.scan_last = (r_idx == AW'(HISTORY_DEPTH - 1));

    // rings: one write port, one registered read port each
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (i_cmd.push && w_sel == 2'(k)) begin
                r_mem[k][r_wr[k]] <= i_sample_time;
            end
            r_rd[k] <= r_mem[k][r_idx];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_fill[k] <= '0;
                r_wr[k]   <= '0;
            end
            r_thresh     <= ThresholdReset;
            r_left_num   <= '0;
            r_left_time  <= '0;
            r_left_held  <= 1'b0;
            r_right_num  <= '0;
            r_right_held <= 1'b0;
            r_idx        <= '0;
            r_cmp_vld    <= 1'b0;
        end else begin
            if (i_cfg_we) r_thresh <= i_cfg_data;
            if (i_cmd.push) begin
                for (int k = 0; k < 3; k++) begin
                    if (w_sel == 2'(k)) begin
                        r_wr[k] <= (r_wr[k] == AW'(HISTORY_DEPTH - 1)) ? '0 : r_wr[k] + 1'b1;
                        if (r_fill[k] != FW'(HISTORY_DEPTH)) r_fill[k] <= r_fill[k] + 1'b1;
                    end
                end
            end
            if (i_cmd.cam0) begin
                r_left_num  <= i_frame_number;
                r_left_time <= i_sample_time;
                r_left_held <= i_frame_present;
            end
            if (i_cmd.cam1) begin
                r_right_num  <= i_frame_number;
                r_right_held <= i_frame_present && !o_stat.match;
                if (o_stat.match) r_left_held <= 1'b0;
            end
            // scan address sweep; compare follows the read in the next cycle
            if (i_cmd.scan_start) begin
                r_idx     <= '0;
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_cmp_idx <= r_idx;
                r_cmp_vld <= 1'b1;
                if (!o_stat.scan_last) r_idx <= r_idx + 1'b1;
            end else begin
                r_cmp_vld <= 1'b0;
            end
        end
    end

    // nearest tracker: one subtract/compare per stream per cycle
    logic [63:0] w_d  [3];
    logic        w_in [3];
    for (genvar k = 0; k < 3; k++) begin : g_best
        assign w_d[k]  = (r_rd[k] >= r_left_time) ? r_rd[k] - r_left_time
                                                  : r_left_time - r_rd[k];
        assign w_in[k] = (FW'(r_cmp_idx) < r_fill[k]);
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (i_cmd.scan_start) begin
                r_found[k] <= 1'b0;
            end else if (r_cmp_vld && w_in[k] && (!r_found[k] || w_d[k] < r_best_d[k])) begin
                r_found[k]  <= 1'b1;
                r_best_d[k] <= w_d[k];
                r_best_t[k] <= r_rd[k];
                r_best_s[k] <= r_cmp_idx;
            end
        end
    end

    // result fields
    function automatic logic [63:0] sat_gap(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] d;
        begin
            if (a >= b) begin
                d = a - b;
                sat_gap = (d > SMAX) ? SMAX : d;
            end else begin
                d = b - a;
                sat_gap = (d > SMAX) ? 64'h8000_0000_0000_0000 : (64'd0 - d);
            end
        end
    endfunction

    logic [1:0]  w_st  [3];
    logic [6:0]  w_sl  [3];
    logic [63:0] w_gp  [3];
    for (genvar k = 0; k < 3; k++) begin : g_res
        assign w_st[k] = !r_found[k] ? STAT_NONE
                       : (r_best_d[k] <= r_thresh) ? STAT_WITHIN : STAT_OUT;
        assign w_sl[k] = r_found[k] ? 7'(r_best_s[k]) : 7'd0;
        assign w_gp[k] = r_found[k] ? sat_gap(r_best_t[k], r_left_time) : 64'd0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_set_frame_number <= r_left_num;
            o_set_time         <= r_left_time;
            o_pose_status  <= w_st[0]; o_pose_slot  <= w_sl[0]; o_pose_gap  <= w_gp[0];
            o_gyro_status  <= w_st[1]; o_gyro_slot  <= w_sl[1]; o_gyro_gap  <= w_gp[1];
            o_accel_status <= w_st[2]; o_accel_slot <= w_sl[2]; o_accel_gap <= w_gp[2];
        end
    end

endmodule

// ===== src/sfts_ctrl.sv =====
// sfts_ctrl: controller state machine and handshakes.
// Depends on sfts_pkg.
module sfts_ctrl
    import sfts_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [2:0] i_func,
    output logic       o_valid,
    input  logic       i_stall,
    output t_cmd       o_cmd,
    input  t_stat      i_stat
);
    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DRAIN, S_FIN, S_OUT} t_state;
    t_state r_state;
    logic   w_acc;

    assign o_stall = (r_state != S_IDLE);
    assign w_acc   = i_valid && !o_stall;

    always_comb begin
        o_cmd = '0;
        o_cmd.push       = w_acc && (i_func == FUNC_POSE || i_func == FUNC_GYRO
                                     || i_func == FUNC_ACCEL);
        o_cmd.cam0       = w_acc && i_func == FUNC_CAM0;
        o_cmd.cam1       = w_acc && i_func == FUNC_CAM1;
        o_cmd.scan_start = o_cmd.cam1 && i_stat.match;
        o_cmd.scan_step  = (r_state == S_SCAN);
        o_cmd.finish     = (r_state == S_FIN);
    end

    // state and registered valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE:  if (o_cmd.scan_start) r_state <= S_SCAN;
                S_SCAN:  if (i_stat.scan_last) r_state <= S_DRAIN;
                S_DRAIN: r_state <= S_FIN;
                S_FIN: begin
                    r_state <= S_OUT;
                    o_valid <= 1'b1;
                end
                S_OUT: if (!i_stall) begin
                    r_state <= S_IDLE;
                    o_valid <= 1'b0;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_valid_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == S_OUT) else $error("valid outside output state");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> o_stall) else $error("accept during scan");
    a_start_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.scan_start |=> r_state == S_SCAN) else $error("scan did not start");
endmodule

// ===== src/sensor_frame_timestamp_syncer_unit.sv =====
// Sensor frame timestamp syncer top level: controller plus datapath.
// Depends on sfts_pkg, sfts_ctrl, sfts_datapath.
// Motion, camera0 and unmatched camera1 beats are taken while idle and leave the unit idle.
// A matching camera1 beat scans HISTORY_DEPTH slots, one per cycle through the
// ring read port, then drains, finishes and holds the result valid; input stalls until taken.
// Reset (synchronous, active low) clears fills, write slots, marks; restores default threshold.
module sensor_frame_timestamp_syncer_unit
    import sfts_pkg::*;
#(
    parameter int unsigned HISTORY_DEPTH = HistoryDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_func,
    input  logic [63:0] i_sample_time,
    input  logic [31:0] i_frame_number,
    input  logic        i_frame_present,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [63:0] i_cfg_threshold_ns,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_set_frame_number,
    output logic [63:0] o_set_time,
    output logic [1:0]  o_pose_status,
    output logic [6:0]  o_pose_slot,
    output logic [63:0] o_pose_gap,
    output logic [1:0]  o_gyro_status,
    output logic [6:0]  o_gyro_slot,
    output logic [63:0] o_gyro_gap,
    output logic [1:0]  o_accel_status,
    output logic [6:0]  o_accel_slot,
    output logic [63:0] o_accel_gap
);
    t_cmd  w_cmd;
    t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    sfts_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_func,
        .o_valid, .i_stall, .o_cmd(w_cmd), .i_stat(w_stat)
    );

    sfts_datapath #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_stat(w_stat),
        .i_func, .i_sample_time, .i_frame_number, .i_frame_present,
        .i_cfg_we(i_cfg_valid), .i_cfg_data(i_cfg_threshold_ns),
        .o_set_frame_number, .o_set_time,
        .o_pose_status, .o_pose_slot, .o_pose_gap,
        .o_gyro_status, .o_gyro_slot, .o_gyro_gap,
        .o_accel_status, .o_accel_slot, .o_accel_gap
    );
endmodule
